[rtl/core/ple_pkg.sv]
package ple_pkg;

  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] position;
    elem_t            element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    elem_t              element_out;
    logic [COUNT_W-1:0] count;
    elem_t              first_element;
    elem_t              last_element;
  } out_item_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  rem;
    idx_t  pos;
    idx_t  sel;
    elem_t wr_elem;
  } cell_ctl_t;

endpackage

[rtl/core/ple_cell.sv]
module ple_cell (
  input  logic               clk,
  input  ple_pkg::idx_t      idx,
  input  ple_pkg::cell_ctl_t ctl,
  input  ple_pkg::elem_t     left_value,
  input  ple_pkg::elem_t     right_value,
  output ple_pkg::elem_t     value,
  output ple_pkg::elem_t     tap
);

  ple_pkg::elem_t value_r;
  ple_pkg::elem_t value_nxt;

  // An insert shifts cells above the position up; a remove pulls them down.
  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        value_nxt = ctl.wr_elem;
      end else if (idx > ctl.pos) begin
        value_nxt = left_value;
      end
    end else if (ctl.rem) begin
      if (idx >= ctl.pos) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign tap   = (idx == ctl.sel) ? value_r : '0;

endmodule

[rtl/core/ple_chain.sv]
module ple_chain (
  input  logic               clk,
  input  ple_pkg::cell_ctl_t ctl,
  output ple_pkg::elem_t     first_value,
  output ple_pkg::elem_t     sel_value
);

  ple_pkg::elem_t values [ple_pkg::CAPACITY];
  ple_pkg::elem_t taps   [ple_pkg::CAPACITY];

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    ple_pkg::elem_t left_v;
    ple_pkg::elem_t right_v;

    if (i == 0) begin : g_lo
      assign left_v = '0;
    end else begin : g_lo_n
      assign left_v = values[i-1];
    end

    if (i == ple_pkg::CAPACITY - 1) begin : g_hi
      assign right_v = '0;
    end else begin : g_hi_n
      assign right_v = values[i+1];
    end

    ple_cell u_cell (
      .clk         (clk),
      .idx         (ple_pkg::IDX_W'(i)),
      .ctl         (ctl),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (values[i]),
      .tap         (taps[i])
    );
  end

  // Only the selected cell drives a nonzero tap, so an OR collects it.
  always_comb begin
    sel_value = '0;
    for (int k = 0; k < ple_pkg::CAPACITY; k++) begin
      sel_value = sel_value | taps[k];
    end
  end

  assign first_value = values[0];

endmodule

[rtl/core/positional_list_engine.sv]
// A transaction's status and result are registered on accept; its finish step then
// loads them into the output register, waiting while out_stall holds an earlier result.
// No new transaction is taken until the current one has finished; the chain updates in the
// accept cycle and the shared select tree reads the new last entry in the following cycle.
// Reset (rst_n low, synchronous) empties the list and clears all handshake state;
// the cell contents are not reset, since entries at or above the count are never read.
module positional_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ple_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]                 status_r, status_nxt;
  ple_pkg::elem_t             res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ple_pkg::out_item_t         out_data_r, out_data_nxt;

  ple_pkg::cell_ctl_t         ctl;
  ple_pkg::elem_t             first_value;
  ple_pkg::elem_t             sel_value;

  logic                       accept;
  logic                       out_free;
  logic [ple_pkg::CMP_W-1:0]  pos_c;
  logic [ple_pkg::CMP_W-1:0]  cnt_c;
  logic [ple_pkg::CMP_W-1:0]  ins_pos;
  logic [ple_pkg::CMP_W-1:0]  rr_pos;
  logic                       past_end;
  logic [ple_pkg::CNT_W-1:0]  last_idx;

  // The input side is open whenever no transaction is waiting for its
  // last-entry lookup; a pending result in the output register does not block it.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Position clamping. Insert clamps to the count (append); remove and read
  // clamp to the last entry, and read reports past-end positions as errors.
  assign pos_c    = ple_pkg::CMP_W'(in_data.position);
  assign cnt_c    = ple_pkg::CMP_W'(cnt_r);
  assign past_end = (pos_c >= cnt_c);
  assign ins_pos  = (pos_c > cnt_c) ? cnt_c : pos_c;
  assign rr_pos   = past_end ? (cnt_c - 1'b1) : pos_c;
  assign last_idx = cnt_r - 1'b1;

  always_comb begin
    ctl         = '0;
    ctl.pos     = ins_pos[ple_pkg::IDX_W-1:0];
    ctl.wr_elem = in_data.element;
    status_nxt  = status_r;
    res_nxt     = res_r;
    cnt_nxt     = cnt_r;

    if (state_r == ST_IDLE) begin
      ctl.sel = rr_pos[ple_pkg::IDX_W-1:0];
    end else begin
      ctl.sel = last_idx[ple_pkg::IDX_W-1:0];
    end

    if (accept) begin
      status_nxt = ple_pkg::STAT_OK;
      res_nxt    = '0;
      unique case (in_data.cmd)
        ple_pkg::CMD_INSERT: begin
          if (cnt_r >= ple_pkg::CNT_W'(ple_pkg::CAPACITY)) begin
            status_nxt = ple_pkg::STAT_FULL;
          end else begin
            ctl.ins = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        ple_pkg::CMD_REMOVE: begin
          if (cnt_r == '0) begin
            status_nxt = ple_pkg::STAT_EMPTY;
          end else begin
            ctl.rem = 1'b1;
            ctl.pos = rr_pos[ple_pkg::IDX_W-1:0];
            res_nxt = sel_value;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        ple_pkg::CMD_READ: begin
          if (cnt_r == '0) begin
            status_nxt = ple_pkg::STAT_EMPTY;
          end else if (past_end) begin
            status_nxt = ple_pkg::STAT_RANGE;
          end else begin
            res_nxt = sel_value;
          end
        end
        default: begin
          status_nxt = ple_pkg::STAT_RANGE;
        end
      endcase
    end
  end

  ple_chain u_chain (
    .clk         (clk),
    .ctl         (ctl),
    .first_value (first_value),
    .sel_value   (sel_value)
  );

  // Finish step: the chain now holds the updated list, so the select tree
  // returns the last entry. The result is loaded once the output register frees up.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data_nxt.status      = status_r;
          out_data_nxt.element_out = res_r;
          out_data_nxt.count       = ple_pkg::COUNT_W'(cnt_r);
          if (cnt_r == '0) begin
            out_data_nxt.first_element = '0;
            out_data_nxt.last_element  = '0;
          end else begin
            out_data_nxt.first_element = first_value;
            out_data_nxt.last_element  = sel_value;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r   <= status_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The list never holds more entries than it has cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  // A result only appears out of the finish step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result produced without a finish step");

  // A newly presented result reports the current entry count.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_data_r.count == ple_pkg::COUNT_W'(cnt_r))
    else $error("result count does not match list count");

  // An empty-list error always comes with an empty list.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ple_pkg::STAT_EMPTY) |->
      (out_data_r.count == '0 && out_data_r.first_element == '0))
    else $error("empty status reported on a non-empty list");

endmodule
